/* rtl/mfvn_pkg.sv */
// Package for the mesh normal engine: types and fixed constants.
`timescale 1ns / 1ps
package mfvn_pkg;

    localparam int unsigned IDX_W   = 10;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned NORM_W  = 16;
    localparam int unsigned ACC_W   = 24;
    localparam int unsigned VEC_W   = 36;
    localparam int unsigned MAG_W   = 30;
    localparam int unsigned SUM_W   = 62;
    localparam int unsigned ROOT_W  = 63;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned REM_W   = 34;
    localparam int unsigned NUM_W   = 45;
    localparam int unsigned QUO_W   = 15;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_FACE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_CROSS,
        S_QREAD,
        S_MAG,
        S_SQ,
        S_SQRT,
        S_DIV,
        S_EMIT,
        S_ACC
    } t_state;

endpackage

/* rtl/mfvn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mfvn_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/mesh_face_and_vertex_normals_top.sv */
// Top level of the mesh normal engine: sequencer, shared arithmetic and stores.
//
//  channel | signals                                   | direction | moves
//  --------+-------------------------------------------+-----------+-----------------------
//  in      | i_in_valid, o_in_stall, request fields    | into core | one request item
//  out     | o_out_valid, i_out_stall, normal fields   | out       | one normal result item
//
// Work: a load stores the vertex and zeroes its accumulator entry as it is accepted; a face
// and a query both run the 32-step square root and the 15-step divide per component. The
// cross products and the squares share one multiplier; the root and the divide each compare.
// Reset: a clearing pass writes zero to every accumulator entry, one per cycle,
// with o_in_stall high throughout.
// Stalls: a result waits in the output register; the sequencer holds in its emit step only
// while that register is still full and stalled.
`timescale 1ns / 1ps
module mesh_face_and_vertex_normals_top #(
    parameter int unsigned VERTEX_COUNT = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_req_type,
    input  logic [mfvn_pkg::IDX_W-1:0]             i_vertex_index,
    input  logic signed [mfvn_pkg::COORD_W-1:0]    i_coord_x,
    input  logic signed [mfvn_pkg::COORD_W-1:0]    i_coord_y,
    input  logic signed [mfvn_pkg::COORD_W-1:0]    i_coord_z,
    input  logic [mfvn_pkg::IDX_W-1:0]             i_corner_a,
    input  logic [mfvn_pkg::IDX_W-1:0]             i_corner_b,
    input  logic [mfvn_pkg::IDX_W-1:0]             i_corner_c,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [mfvn_pkg::NORM_W-1:0]     o_normal_x,
    output logic signed [mfvn_pkg::NORM_W-1:0]     o_normal_y,
    output logic signed [mfvn_pkg::NORM_W-1:0]     o_normal_z,
    output logic                                   o_degenerate,
    output logic                                   o_is_vertex_normal
);
    import mfvn_pkg::*;

    // Only indices the 10-bit fields can reach need storage.
    localparam int unsigned DEPTH = (VERTEX_COUNT < 1024) ? VERTEX_COUNT : 1024;
    localparam int unsigned AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    // Request registers.
    logic                      r_is_face;
    logic [IDX_W-1:0]          r_vidx;
    logic                      r_vidx_ok;
    logic [IDX_W-1:0]          r_corner [3];
    logic                      r_cok [3];

    // Datapath registers.
    logic [4:0]                r_cnt;
    logic [1:0]                r_comp;
    logic [AW-1:0]             r_clr;
    logic signed [COORD_W-1:0] r_p [3][3];
    logic signed [VEC_W-1:0]   r_c [3];
    logic [MAG_W-1:0]          r_mag [3];
    logic                      r_neg [3];
    logic signed [63:0]        r_prod;
    logic [SUM_W-1:0]          r_sum;
    logic [ROOT_W-1:0]         r_root;
    logic [REM_W-1:0]          r_rem;
    logic [QUO_W-1:0]          r_q;
    logic signed [NORM_W-1:0]  r_n [3];
    logic                      r_degen;
    logic                      r_out_valid;

    // Handshake and store controls.
    logic                      accept;
    logic                      out_load;
    logic                      v_we, a_we;
    logic [AW-1:0]             v_waddr, v_raddr, a_waddr, a_raddr;
    logic [3*COORD_W-1:0]      v_wdata, v_rdata;
    logic [3*ACC_W-1:0]        a_wdata, a_rdata;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < VERTEX_COUNT;
    endfunction

    assign accept = i_in_valid && !o_in_stall;

    mfvn_ram #(.WIDTH(3*COORD_W), .DEPTH(DEPTH)) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    mfvn_ram #(.WIDTH(3*ACC_W), .DEPTH(DEPTH)) u_accum_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    // Edge vectors of the face, fed to the shared multiplier.
    logic signed [COORD_W:0] da [3];
    logic signed [COORD_W:0] db [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            da[i] = {r_p[1][i][COORD_W-1], r_p[1][i]} - {r_p[0][i][COORD_W-1], r_p[0][i]};
            db[i] = {r_p[2][i][COORD_W-1], r_p[2][i]} - {r_p[0][i][COORD_W-1], r_p[0][i]};
        end
    end

    // Cross component that the product in hand belongs to.
    logic [1:0] cr_idx;
    assign cr_idx = 2'((r_cnt - 5'd1) >> 1);

    // Shared multiplier operand select.
    logic signed [31:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_CROSS) begin
            unique case (r_cnt)
                5'd0: begin mul_a = 32'(da[1]); mul_b = 32'(db[2]); end
                5'd1: begin mul_a = 32'(da[2]); mul_b = 32'(db[1]); end
                5'd2: begin mul_a = 32'(da[2]); mul_b = 32'(db[0]); end
                5'd3: begin mul_a = 32'(da[0]); mul_b = 32'(db[2]); end
                5'd4: begin mul_a = 32'(da[0]); mul_b = 32'(db[1]); end
                5'd5: begin mul_a = 32'(da[1]); mul_b = 32'(db[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == S_SQ && r_cnt < 5'd3) begin
            mul_a = {2'b00, r_mag[r_cnt[1:0]]};
            mul_b = {2'b00, r_mag[r_cnt[1:0]]};
        end
    end

    // Magnitudes and the common reduction shift.
    logic [VEC_W-1:0] mag_full [3];
    logic [VEC_W-1:0] max_mag;
    logic [2:0]       red_sh;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_full[i] = r_c[i][VEC_W-1] ? VEC_W'(-r_c[i]) : VEC_W'(r_c[i]);
        end
        max_mag = mag_full[0] | mag_full[1] | mag_full[2];
        priority if (max_mag[35]) red_sh = 3'd6;
        else if (max_mag[34])     red_sh = 3'd5;
        else if (max_mag[33])     red_sh = 3'd4;
        else if (max_mag[32])     red_sh = 3'd3;
        else if (max_mag[31])     red_sh = 3'd2;
        else if (max_mag[30])     red_sh = 3'd1;
        else                      red_sh = 3'd0;
    end

    // Square root step: one bit pair per cycle.
    logic [ROOT_W-1:0] sq_bit, sq_try;
    logic              sq_take;
    assign sq_bit  = ROOT_W'(1) << {r_cnt, 1'b0};
    assign sq_try  = r_root + sq_bit;
    assign sq_take = {1'b0, r_sum} >= sq_try;

    // Divide step: one quotient bit per cycle.
    logic [LEN_W-1:0] len;
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] dv_try;
    logic             dv_take;
    assign len     = r_root[LEN_W-1:0];
    assign num     = {1'b0, r_mag[r_comp], 14'd0} + NUM_W'(len >> 1);
    assign dv_try  = {r_rem[REM_W-2:0], num[r_cnt[3:0]]};
    assign dv_take = dv_try >= {2'b00, len};

    // Saturating accumulator update for the corner in hand.
    logic [ACC_W-1:0] acc_new [3];
    always_comb begin
        logic signed [ACC_W:0] s;
        for (int i = 0; i < 3; i++) begin
            s = $signed({a_rdata[(2-i)*ACC_W+ACC_W-1], a_rdata[(2-i)*ACC_W +: ACC_W]})
                + (ACC_W+1)'(r_n[i]);
            if (s > $signed((ACC_W+1)'(8388607)))       acc_new[i] = 24'h7FFFFF;
            else if (s < $signed(-(ACC_W+1)'(8388608))) acc_new[i] = 24'h800000;
            else                                        acc_new[i] = s[ACC_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept && i_req_type == REQ_FACE)  n_state = S_FETCH;
                if (accept && i_req_type == REQ_QUERY) n_state = S_QREAD;
            end
            S_FETCH: if (r_cnt == 5'd3) n_state = S_CROSS;
            S_CROSS: if (r_cnt == 5'd6) n_state = S_MAG;
            S_QREAD: if (r_cnt == 5'd1) n_state = S_MAG;
            S_MAG:   n_state = S_SQ;
            S_SQ:    if (r_cnt == 5'd3) n_state = S_SQRT;
            S_SQRT:  if (r_cnt == 5'd0) n_state = S_DIV;
            S_DIV: begin
                if (len == '0 || (r_cnt == 5'd0 && r_comp == 2'd2)) n_state = S_EMIT;
            end
            S_EMIT:  if (out_load) n_state = r_is_face ? S_ACC : S_IDLE;
            S_ACC:   if (r_cnt == 5'd5) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Store and handshake controls.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        out_load   = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
        v_we       = accept && i_req_type == REQ_LOAD && in_range(i_vertex_index);
        v_waddr    = i_vertex_index[AW-1:0];
        v_wdata    = {i_coord_x, i_coord_y, i_coord_z};
        v_raddr    = r_corner[(r_cnt < 5'd3) ? r_cnt[1:0] : 2'd2][AW-1:0];
        a_we       = 1'b0;
        a_waddr    = r_clr;
        a_wdata    = '0;
        a_raddr    = r_vidx[AW-1:0];
        unique case (r_state)
            S_CLEAR: a_we = 1'b1;
            S_IDLE: begin
                a_we    = v_we;
                a_waddr = i_vertex_index[AW-1:0];
            end
            S_ACC: begin
                a_raddr = r_corner[r_cnt[2:1]][AW-1:0];
                a_waddr = r_corner[r_cnt[2:1]][AW-1:0];
                a_we    = r_cnt[0] && r_cok[r_cnt[2:1]];
                a_wdata = {acc_new[0], acc_new[1], acc_new[2]};
            end
            default: a_we = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_comp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (n_state != r_state) begin
                r_comp <= '0;
                priority case (n_state)
                    S_SQRT:  r_cnt <= 5'd31;
                    S_DIV:   r_cnt <= 5'd15;
                    default: r_cnt <= '0;
                endcase
            end else if (r_state == S_SQRT) begin
                r_cnt <= r_cnt - 5'd1;
            end else if (r_state == S_DIV) begin
                if (r_cnt == 5'd0) begin
                    r_cnt  <= 5'd15;
                    r_comp <= r_comp + 2'd1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end else begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (out_load)                         r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (accept) begin
            r_is_face   <= (i_req_type == REQ_FACE);
            r_vidx      <= i_vertex_index;
            r_vidx_ok   <= in_range(i_vertex_index);
            r_corner[0] <= i_corner_a;
            r_corner[1] <= i_corner_b;
            r_corner[2] <= i_corner_c;
            r_cok[0]    <= in_range(i_corner_a);
            r_cok[1]    <= in_range(i_corner_b);
            r_cok[2]    <= in_range(i_corner_c);
        end
        unique case (r_state)
            S_FETCH: begin
                if (r_cnt != 5'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_p[r_cnt[1:0]-2'd1][i] <= r_cok[r_cnt[1:0]-2'd1]
                            ? v_rdata[(2-i)*COORD_W +: COORD_W] : '0;
                    end
                end
            end
            S_CROSS: begin
                // Even products start a component, odd ones subtract from it.
                if (r_cnt != 5'd0) begin
                    if (r_cnt[0]) r_c[cr_idx] <= VEC_W'(r_prod);
                    else r_c[cr_idx] <= r_c[cr_idx] - VEC_W'(r_prod);
                end
            end
            S_QREAD: begin
                if (r_cnt == 5'd1) begin
                    for (int i = 0; i < 3; i++) begin
                        r_c[i] <= r_vidx_ok
                            ? VEC_W'($signed(a_rdata[(2-i)*ACC_W +: ACC_W])) : '0;
                    end
                end
            end
            S_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= MAG_W'(mag_full[i] >> red_sh);
                    r_neg[i] <= r_c[i][VEC_W-1];
                end
                r_sum <= '0;
            end
            S_SQ: begin
                if (r_cnt != 5'd0) r_sum <= r_sum + SUM_W'(r_prod);
                r_root <= '0;
            end
            S_SQRT: begin
                if (sq_take) begin
                    r_sum  <= SUM_W'({1'b0, r_sum} - sq_try);
                    r_root <= (r_root >> 1) + sq_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_rem <= '0;
            end
            S_DIV: begin
                if (len == '0) begin
                    r_degen <= 1'b1;
                    for (int i = 0; i < 3; i++) r_n[i] <= '0;
                end else if (r_cnt == 5'd15) begin
                    r_degen <= 1'b0;
                    r_rem   <= REM_W'(num >> QUO_W);
                    r_q     <= '0;
                end else begin
                    r_rem <= dv_take ? dv_try - {2'b00, len} : dv_try;
                    r_q   <= {r_q[QUO_W-2:0], dv_take};
                    if (r_cnt == 5'd0) begin
                        r_n[r_comp] <= r_neg[r_comp]
                            ? -NORM_W'({r_q[QUO_W-2:0], dv_take})
                            : NORM_W'({r_q[QUO_W-2:0], dv_take});
                    end
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            o_normal_x         <= r_n[0];
            o_normal_y         <= r_n[1];
            o_normal_z         <= r_n[2];
            o_degenerate       <= r_degen;
            o_is_vertex_normal <= !r_is_face;
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks.
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> o_in_stall)
        else $error("input taken during accumulator clearing");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result appeared outside the emit step");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |->
        o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
        else $error("degenerate result carries a non-zero normal");

    a_acc_only_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACC |-> r_is_face)
        else $error("accumulator update for a non-face item");

endmodule
